@@ rtl/itoa_pkg.sv @@
// itoa_pkg: shared constants and the digit-to-ascii glyph function
// for the radix conversion block; no dependencies
package itoa_pkg;

  // quotient bits retired by the divider per clock
  localparam int DIV_BITS = 8;

  // digit and character widths
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;
  localparam int RADIX_W = 5;
  localparam int MINC_W  = 7;

  // legal radix range, out-of-range values saturate to these
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // ascii codes for the two glyph groups
  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A_BASE = 7'h37;  // 'A' minus ten

  // uppercase hex glyph for one digit
  function automatic logic [CHAR_W-1:0] to_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {3'b000, d};
    end else begin
      c = ASCII_A_BASE + {3'b000, d};
    end
    return c;
  endfunction

endpackage

@@ rtl/integer_to_ascii_radix.sv @@
// integer_to_ascii_radix: converts an unsigned value to uppercase ascii text
// in radix 2..16; uses itoa_pkg and one itoa_ram instance for the digit store
//
// usage
//   input channel (in_valid/in_ready): in_number, in_radix, in_min_chars.
//   in_ready is high only while no conversion is in flight; one item at a time.
//   result channel (out_valid/out_ready): out_char_out, one ascii character
//   per transfer, most significant first; out_last marks the final character.
//   radix below 2 or above 16 saturates; min_chars above MAX_CHARS is capped.
// datapath
//   each digit is formed by the divider, which retires 8 quotient bits per
//   cycle; digits are stored least significant first, then pad characters.
//   each character is read through the digit store's single read port, then
//   converted to its glyph in the output register.
// reset and stalls
//   rst_n low returns the block to idle with out_valid low; the digit store
//   needs no clearing since each conversion writes every entry it reads.
//   a stalled receiver holds the character in the output register; the block
//   simply waits, no data is lost.
module integer_to_ascii_radix #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_CHARS  = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_number,
  input  logic [itoa_pkg::RADIX_W-1:0]    in_radix,
  input  logic [itoa_pkg::MINC_W-1:0]     in_min_chars,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]     out_char_out,
  output logic                            out_last
);

  localparam int NCH = (VALUE_BITS + itoa_pkg::DIV_BITS - 1) / itoa_pkg::DIV_BITS;
  localparam int QW  = NCH * itoa_pkg::DIV_BITS;
  localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int AW  = $clog2(MAX_CHARS);
  localparam int CW  = $clog2(MAX_CHARS + 1);
  localparam int DW  = itoa_pkg::DIGIT_W;
  localparam int RW  = itoa_pkg::RADIX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PAD,
    S_LD,
    S_OUT
  } state_t;

  state_t                       state_r;
  logic [QW-1:0]                q_r;
  logic [RW-1:0]                base_r;
  logic [CW-1:0]                width_r;
  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                k_r;
  logic [CHW-1:0]               ch_r;
  logic [DW-1:0]                rem_r;
  logic                         out_valid_r;
  logic                         out_last_r;
  logic [itoa_pkg::CHAR_W-1:0]  out_char_r;

  logic [itoa_pkg::DIV_BITS-1:0] top_bits;
  logic [itoa_pkg::DIV_BITS-1:0] qbits;
  logic [DW-1:0]                 rem_nxt;
  logic [QW-1:0]                 q_nxt;
  logic [CW-1:0]                 cnt_nxt;
  logic                          ch_last;
  logic                          pad_more;
  logic                          out_xfer;
  logic [CW-1:0]                 rd_cnt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // long division by the radix, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [RW-1:0] r5;
    logic [DW-1:0] rem;
    rem      = rem_r;
    qbits    = '0;
    top_bits = q_r[QW-1 -: itoa_pkg::DIV_BITS];
    for (int i = itoa_pkg::DIV_BITS - 1; i >= 0; i--) begin
      r5 = {rem, top_bits[i]};
      if (r5 >= base_r) begin
        r5       = r5 - base_r;
        qbits[i] = 1'b1;
      end
      rem = r5[DW-1:0];
    end
    rem_nxt = rem;
    q_nxt   = (q_r << itoa_pkg::DIV_BITS) | QW'(qbits);
  end

  assign ch_last  = (ch_r == CHW'(NCH - 1));
  assign cnt_nxt  = cnt_r + CW'(1);
  assign pad_more = (cnt_r < width_r);
  assign out_xfer = out_valid_r && out_ready;

  // digit store access: writes during division and padding, reads at the end of padding and when emitting
  assign ram_we    = ((state_r == S_DIV) && ch_last) || ((state_r == S_PAD) && pad_more);
  assign ram_waddr = cnt_r[AW-1:0];
  assign ram_wdata = (state_r == S_DIV) ? rem_nxt : '0;
  assign ram_re    = ((state_r == S_PAD) && !pad_more) ||
                     ((state_r == S_OUT) && out_xfer && !out_last_r);
  assign rd_cnt    = (state_r == S_PAD) ? (cnt_r - CW'(1)) : (k_r - CW'(2));
  assign ram_raddr = rd_cnt[AW-1:0];

  itoa_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_CHARS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: divide, pad, then read back and emit most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      cnt_r       <= '0;
      q_r         <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            q_r   <= QW'(in_number[VALUE_BITS-1:0]);
            rem_r <= '0;
            ch_r  <= '0;
            cnt_r <= '0;
            if (in_radix < itoa_pkg::RADIX_MIN) begin
              base_r <= itoa_pkg::RADIX_MIN;
            end else if (in_radix > itoa_pkg::RADIX_MAX) begin
              base_r <= itoa_pkg::RADIX_MAX;
            end else begin
              base_r <= in_radix;
            end
            if (in_min_chars > itoa_pkg::MINC_W'(MAX_CHARS)) begin
              width_r <= CW'(MAX_CHARS);
            end else begin
              width_r <= CW'(in_min_chars);
            end
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          q_r <= q_nxt;
          if (ch_last) begin
            // digit done: stored this cycle, restart remainder for the next one
            rem_r <= '0;
            ch_r  <= '0;
            cnt_r <= cnt_nxt;
            if ((q_nxt == '0) || (cnt_nxt >= CW'(MAX_CHARS))) begin
              state_r <= S_PAD;
            end
          end else begin
            rem_r <= rem_nxt;
            ch_r  <= ch_r + CHW'(1);
          end
        end
        S_PAD: begin
          if (pad_more) begin
            cnt_r <= cnt_nxt;
          end else begin
            // first read of the top digit is issued this cycle
            k_r     <= cnt_r;
            state_r <= S_LD;
          end
        end
        S_LD: begin
          out_char_r  <= itoa_pkg::to_glyph(ram_rdata);
          out_last_r  <= (k_r == CW'(1));
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_xfer) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r - CW'(1);
              state_r <= S_LD;
            end
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

`ifndef SYNTH
  // no new item is taken while a character is still offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // digit store writes stay inside the store
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (cnt_r < CW'(MAX_CHARS)))
    else $error("digit store write beyond its depth");

  // the last character transfer returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("block not idle after the final character");

  // a character is flagged last exactly when one position remains
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD) |=> (out_last == (k_r == CW'(1))))
    else $error("last flag does not match the remaining count");
`endif

endmodule

@@ rtl/itoa_ram.sv @@
// itoa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
